FILE: rtl/ps2m_pkg.sv
`timescale 1ns / 1ps

package ps2m_pkg;

  // Host command codes
  typedef enum logic [7:0] {
    CMD_SCALE_OFF = 8'hE6,
    CMD_SCALE_ON  = 8'hE7,
    CMD_SET_RES   = 8'hE8,
    CMD_STATUS    = 8'hE9,
    CMD_GET_ID    = 8'hF2,
    CMD_SET_RATE  = 8'hF3,
    CMD_ENABLE    = 8'hF4,
    CMD_DISABLE   = 8'hF5,
    CMD_RESET     = 8'hFF
  } cmd_t;

  // Device reply bytes
  localparam logic [7:0] ACK_BYTE    = 8'hFA;
  localparam logic [7:0] RESEND_BYTE = 8'hFE;
  localparam logic [7:0] ERROR_BYTE  = 8'hFC;
  localparam logic [7:0] SELFTEST_OK = 8'hAA;
  localparam logic [7:0] ID_WHEEL    = 8'h03;
  localparam logic [7:0] ID_PLAIN    = 8'h00;

  // Host queue: 16 entries, motion is held back at 13 or more pending bytes
  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned QFILL_W     = $clog2(QUEUE_DEPTH);
  localparam logic [QFILL_W-1:0] ROOM_LIMIT = QFILL_W'(13);

  // Rate sequence that unlocks wheel mode, oldest byte first
  localparam logic [0:5][7:0] MAGIC_SEQ = {8'hF3, 8'hC8, 8'hF3, 8'h64, 8'hF3, 8'h50};

  // Configuration register indexes
  localparam logic REG_WHEEL_PRESENT = 1'b0;

  localparam int unsigned RUN_MAX = 4;

  // One item's run of reply words
  typedef struct packed {
    logic [RUN_MAX-1:0][7:0] bytes;
    logic [2:0]              len;    // 0 means no reply
  } run_t;

  // Saturate a 17-bit sum to 16 bits
  function automatic logic [15:0] sat16(input logic [16:0] v);
    logic [15:0] r;
    if (v[16] != v[15]) begin
      r = v[16] ? 16'h8000 : 16'h7FFF;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  // Clamp to [-256,255], low eight bits
  function automatic logic [7:0] clamp_xy(input logic [15:0] v);
    logic [7:0] r;
    if ($signed(v) < -16'sd256) begin
      r = 8'h00;
    end else if ($signed(v) > 16'sd255) begin
      r = 8'hFF;
    end else begin
      r = v[7:0];
    end
    return r;
  endfunction

  // Clamp to [-8,7], low eight bits
  function automatic logic [7:0] clamp_z(input logic [15:0] v);
    logic [7:0] r;
    if ($signed(v) < -16'sd8) begin
      r = 8'hF8;
    end else if ($signed(v) > 16'sd7) begin
      r = 8'h07;
    end else begin
      r = v[7:0];
    end
    return r;
  endfunction

endpackage

FILE: rtl/ps2m_core.sv
`timescale 1ns / 1ps

module ps2m_core import ps2m_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               fire,
  input  logic               mode,
  input  logic [7:0]         host_byte,
  input  logic [8:0]         dx,
  input  logic [8:0]         dy,
  input  logic [7:0]         dz,
  input  logic [2:0]         buttons,
  input  logic               scan_enabled,
  input  logic [QFILL_W-1:0] queue_fill,
  input  logic               wheel_present,
  output run_t               run
);

  logic [7:0]       pending_command, pending_command_next;
  logic             arg_pending, arg_pending_next;
  logic [7:0]       resolution_reg, resolution_reg_next;
  logic [7:0]       rate_reg, rate_reg_next;
  logic             scaling_on, scaling_on_next;
  logic             reporting_on, reporting_on_next;
  logic             wheel_mode, wheel_mode_next;
  logic [2:0]       last_buttons, last_buttons_next;
  logic [15:0]      acc_x, acc_x_next;
  logic [15:0]      acc_y, acc_y_next;
  logic [15:0]      acc_z, acc_z_next;
  logic [0:5][7:0]  hist, hist_next, hist_shift;

  logic signed [16:0] sum_x, sum_y, sum_z;
  logic [15:0]        sat_x, sat_y, sat_z;
  logic               moved;
  logic [7:0]         byte0;

  // Accumulator sums, one sign bit of headroom
  assign sum_x = $signed({acc_x[15], acc_x}) + $signed({{8{dx[8]}}, dx});
  assign sum_y = $signed({acc_y[15], acc_y}) - $signed({{8{dy[8]}}, dy});
  assign sum_z = $signed({acc_z[15], acc_z}) - $signed({{9{dz[7]}}, dz});
  assign sat_x = sat16(sum_x);
  assign sat_y = sat16(sum_y);
  assign sat_z = sat16(sum_z);

  assign moved = (dx != '0) || (dy != '0) || (dz != '0) || (buttons != last_buttons);

  // Packet header: sync bit, signs of the clamped x and y, buttons
  assign byte0 = {2'b00, sat_y[15], sat_x[15], 1'b1, wheel_present & buttons[2],
                  buttons[1], buttons[0]};

  // Host byte history, newest last
  always_comb begin
    for (int i = 0; i < 5; i++) begin
      hist_shift[i] = hist[i+1];
    end
    hist_shift[5] = host_byte;
  end

  // Next state and reply run for the word at the input
  always_comb begin
    pending_command_next = pending_command;
    arg_pending_next     = arg_pending;
    resolution_reg_next  = resolution_reg;
    rate_reg_next        = rate_reg;
    scaling_on_next      = scaling_on;
    reporting_on_next    = reporting_on;
    wheel_mode_next      = wheel_mode;
    last_buttons_next    = last_buttons;
    acc_x_next           = acc_x;
    acc_y_next           = acc_y;
    acc_z_next           = acc_z;
    hist_next            = hist;
    run                  = '0;

    if (!mode) begin
      if (arg_pending) begin
        // argument byte of a resolution or rate command
        arg_pending_next = 1'b0;
        run.len          = 3'd1;
        if (pending_command == CMD_SET_RES) begin
          resolution_reg_next = host_byte;
          run.bytes[0]        = ACK_BYTE;
        end else if (pending_command == CMD_SET_RATE) begin
          rate_reg_next = host_byte;
          run.bytes[0]  = ACK_BYTE;
        end else begin
          run.bytes[0] = ERROR_BYTE;
        end
      end else begin
        pending_command_next = host_byte;
        run.len              = 3'd1;
        run.bytes[0]         = ACK_BYTE;
        unique case (host_byte)
          CMD_SCALE_OFF: scaling_on_next = 1'b0;
          CMD_SCALE_ON:  scaling_on_next = 1'b1;
          CMD_SET_RES,
          CMD_SET_RATE:  arg_pending_next = 1'b1;
          CMD_STATUS: begin
            run.len      = 3'd4;
            run.bytes[1] = {2'b00, scaling_on, reporting_on, 1'b0, buttons};
            run.bytes[2] = resolution_reg;
            run.bytes[3] = rate_reg;
          end
          CMD_GET_ID: begin
            run.len      = 3'd2;
            run.bytes[1] = wheel_mode ? ID_WHEEL : ID_PLAIN;
          end
          CMD_ENABLE:  reporting_on_next = 1'b1;
          CMD_DISABLE: reporting_on_next = 1'b0;
          CMD_RESET: begin
            scaling_on_next   = 1'b0;
            reporting_on_next = 1'b0;
            wheel_mode_next   = 1'b0;
            arg_pending_next  = 1'b0;
            run.len           = 3'd3;
            run.bytes[1]      = SELFTEST_OK;
            run.bytes[2]      = 8'h00;
          end
          default: run.bytes[0] = RESEND_BYTE;
        endcase
      end
      // wheel unlock watches every host byte while wheel_present is set
      if (wheel_present) begin
        hist_next = hist_shift;
        if (hist_shift == MAGIC_SEQ) begin
          wheel_mode_next = 1'b1;
        end
      end
    end else if (moved && reporting_on && scan_enabled) begin
      if (queue_fill >= ROOM_LIMIT) begin
        // queue nearly full: keep accumulating
        acc_x_next = sat_x;
        acc_y_next = sat_y;
        acc_z_next = sat_z;
      end else begin
        last_buttons_next = buttons;
        acc_x_next        = '0;
        acc_y_next        = '0;
        acc_z_next        = '0;
        run.len           = wheel_present ? 3'd4 : 3'd3;
        run.bytes[0]      = byte0;
        run.bytes[1]      = clamp_xy(sat_x);
        run.bytes[2]      = clamp_xy(sat_y);
        run.bytes[3]      = clamp_z(sat_z);
      end
    end
  end

  // Device state
  always_ff @(posedge clk) begin
    if (rst) begin
      pending_command <= '0;
      arg_pending     <= 1'b0;
      resolution_reg  <= '0;
      rate_reg        <= '0;
      scaling_on      <= 1'b0;
      reporting_on    <= 1'b0;
      wheel_mode      <= 1'b0;
      last_buttons    <= '0;
      acc_x           <= '0;
      acc_y           <= '0;
      acc_z           <= '0;
      hist            <= '0;
    end else if (fire) begin
      pending_command <= pending_command_next;
      arg_pending     <= arg_pending_next;
      resolution_reg  <= resolution_reg_next;
      rate_reg        <= rate_reg_next;
      scaling_on      <= scaling_on_next;
      reporting_on    <= reporting_on_next;
      wheel_mode      <= wheel_mode_next;
      last_buttons    <= last_buttons_next;
      acc_x           <= acc_x_next;
      acc_y           <= acc_y_next;
      acc_z           <= acc_z_next;
      hist            <= hist_next;
    end
  end

endmodule

FILE: rtl/ps2m_out.sv
`timescale 1ns / 1ps

module ps2m_out import ps2m_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_fire,
  input  run_t       in_run,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] data_byte,
  output logic       last_byte
);

  run_t       pend;
  logic       pend_valid;
  run_t       act;
  logic       act_valid;
  logic [1:0] idx;
  logic       act_free;
  logic       move;

  assign out_valid = act_valid;
  assign data_byte = act.bytes[idx];
  assign last_byte = ({1'b0, idx} == (act.len - 3'd1));

  // Active run frees up once its final word is taken
  assign act_free = !act_valid || (out_ready && last_byte);
  assign move     = pend_valid && act_free;
  assign in_ready = !pend_valid || act_free;

  // Pending run slot
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (in_fire) begin
      pend_valid <= (in_run.len != 3'd0);
    end else if (move) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      pend <= in_run;
    end
  end

  // Active run, shifted out one word a cycle while out_ready is high
  always_ff @(posedge clk) begin
    if (rst) begin
      act_valid <= 1'b0;
      idx       <= '0;
    end else if (act_free) begin
      act_valid <= pend_valid;
      idx       <= '0;
    end else if (out_ready) begin
      idx <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      act <= pend;
    end
  end

endmodule

FILE: rtl/ps2_mouse_device.sv
// A word's reply run is held in the pending-run slot, then moved to the active
// slot once that slot is free, and its first reply byte is offered from there.
// Throughput: a word is accepted every cycle while the pending-run slot is free
// or the active run is giving up its last byte; a run of one to four bytes
// holds the output until its last byte is taken; one more word waits behind it.
// Reset: rst is synchronous and active high; it clears all device state,
// empties the reply buffers and clears the wheel_present register.
`timescale 1ns / 1ps

module ps2_mouse_device import ps2m_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  // input words
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               mode,
  input  logic [7:0]         host_byte,
  input  logic signed [8:0]  dx,
  input  logic signed [8:0]  dy,
  input  logic signed [7:0]  dz,
  input  logic [2:0]         buttons,
  input  logic               scan_enabled,
  input  logic [QFILL_W-1:0] queue_fill,
  // reply bytes
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         data_byte,
  output logic               last_byte,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic wheel_present;
  logic in_fire;
  run_t run;

  assign in_fire = in_valid && in_ready;

  // Configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_WHEEL_PRESENT) ? {31'd0, wheel_present} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      wheel_present <= 1'b0;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_WHEEL_PRESENT) begin
      wheel_present <= pwdata[0];
    end
  end

  ps2m_core u_core (
    .clk          (clk),
    .rst          (rst),
    .fire         (in_fire),
    .mode         (mode),
    .host_byte    (host_byte),
    .dx           (dx),
    .dy           (dy),
    .dz           (dz),
    .buttons      (buttons),
    .scan_enabled (scan_enabled),
    .queue_fill   (queue_fill),
    .wheel_present(wheel_present),
    .run          (run)
  );

  ps2m_out u_out (
    .clk      (clk),
    .rst      (rst),
    .in_fire  (in_fire),
    .in_run   (run),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .data_byte(data_byte),
    .last_byte(last_byte)
  );

endmodule

FILE: rtl/ps2m_checker.sv
`timescale 1ns / 1ps

module ps2m_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  data_byte,
  input logic        last_byte,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [2:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata,
  input logic        pready
);

  logic [2:0] run_cnt;

  // Bytes taken since the last end of run
  always_ff @(posedge clk) begin
    if (rst) begin
      run_cnt <= '0;
    end else if (out_valid && out_ready) begin
      run_cnt <= last_byte ? 3'd0 : run_cnt + 3'd1;
    end
  end

  // A run never exceeds four bytes
  a_run_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready |-> run_cnt < 3'd3 || last_byte)
    else $error("reply run longer than four bytes");

  // Nothing is offered right after reset
  a_reset_idle: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

  // Written register reads back
  a_cfg_readback: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && pready && paddr[2] == 1'b0 |=>
      paddr[2] != 1'b0 || prdata == {31'd0, $past(pwdata[0])})
    else $error("wheel_present readback mismatch");

  // Stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(data_byte) && $stable(last_byte))
    else $error("output word changed while stalled");

endmodule

bind ps2_mouse_device ps2m_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .data_byte(data_byte),
  .last_byte(last_byte),
  .psel     (psel),
  .penable  (penable),
  .pwrite   (pwrite),
  .paddr    (paddr),
  .pwdata   (pwdata),
  .prdata   (prdata),
  .pready   (pready)
);
